[rtl/rv64alu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64alu_pkg
// Types and constants shared by the RV64I execute-stage ALU and its channels.
// ----------------------------------------------------------------------------
package rv64alu_pkg;

  localparam int unsigned XLEN    = 64;
  localparam int unsigned WLEN    = 32;
  localparam int unsigned IMM_W   = 12;
  localparam int unsigned OPC_W   = 7;
  localparam int unsigned F3_W    = 3;
  localparam int unsigned F7_W    = 7;
  localparam int unsigned SHAMT_W = 6;
  localparam int unsigned SHW_W   = 5;

  // Major opcodes handled by the block.
  typedef enum logic [OPC_W-1:0] {
    OPC_LOAD    = 7'h03,
    OPC_OPIMM   = 7'h13,
    OPC_OPIMM32 = 7'h1B,
    OPC_STORE   = 7'h23,
    OPC_OP      = 7'h33,
    OPC_BRANCH  = 7'h63,
    OPC_JALR    = 7'h67,
    OPC_JAL     = 7'h6F
  } opcode_e;

  // Minor operation codes.
  localparam logic [F3_W-1:0] F3_ADD  = 3'd0;
  localparam logic [F3_W-1:0] F3_SLL  = 3'd1;
  localparam logic [F3_W-1:0] F3_SLT  = 3'd2;
  localparam logic [F3_W-1:0] F3_SLTU = 3'd3;
  localparam logic [F3_W-1:0] F3_XOR  = 3'd4;
  localparam logic [F3_W-1:0] F3_SR   = 3'd5;
  localparam logic [F3_W-1:0] F3_OR   = 3'd6;
  localparam logic [F3_W-1:0] F3_AND  = 3'd7;

  localparam logic [F3_W-1:0] F3_BEQ  = 3'd0;
  localparam logic [F3_W-1:0] F3_BNE  = 3'd1;
  localparam logic [F3_W-1:0] F3_BLT  = 3'd4;
  localparam logic [F3_W-1:0] F3_BGE  = 3'd5;

  localparam logic [F7_W-1:0] F7_ALT  = 7'h20;
  localparam int unsigned     IMM_ALT_BIT = 10;
  localparam logic [XLEN-1:0] LINK_OFFSET = 64'd4;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [F3_W-1:0]   funct3;
    logic signed [IMM_W-1:0] imm;
    logic signed [XLEN-1:0]  first_operand;
    logic signed [XLEN-1:0]  second_operand;
    logic [XLEN-1:0]   pc;
  } alu_item_t;

endpackage

[rtl/rv64alu_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64alu_in_if
// Valid/ready channel carrying one instruction beat into the ALU.
// ----------------------------------------------------------------------------
interface rv64alu_in_if
  import rv64alu_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic [F3_W-1:0]         funct3;
  logic signed [IMM_W-1:0] imm;
  logic signed [XLEN-1:0]  first_operand;
  logic signed [XLEN-1:0]  second_operand;
  logic [XLEN-1:0]         pc;

  modport source (
    output valid, opcode, funct3, imm, first_operand, second_operand, pc,
    input  ready
  );

  modport sink (
    input  valid, opcode, funct3, imm, first_operand, second_operand, pc,
    output ready
  );
endinterface

[rtl/rv64alu_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64alu_out_if
// Valid/ready channel carrying one result beat out of the ALU.
// ----------------------------------------------------------------------------
interface rv64alu_out_if
  import rv64alu_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [XLEN-1:0] result;

  modport source (
    output valid, result,
    input  ready
  );

  modport sink (
    input  valid, result,
    output ready
  );
endinterface

[rtl/rv64i_execute_alu.sv]
`timescale 1ns / 1ps
// Each accepted instruction beat passes the input register, then the result register.
// Throughput: one instruction per cycle unless res_o stalls, set by both registers.
// The input register stays full while the result register is stalled, so up to
// two beats are held inside; the block stalls only when both are full.
// Reset clears both valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
// rv64i_execute_alu
// Execute-stage ALU for a subset of RV64I: input register, datapath, result
// register, each register with its own valid flag and backpressure.
// ----------------------------------------------------------------------------
module rv64i_execute_alu
  import rv64alu_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  rv64alu_in_if.sink    in_i,
  rv64alu_out_if.source res_o
);

  logic            s1_valid_q, s1_valid_d;
  alu_item_t       s1_item_q;
  logic            res_valid_q, res_valid_d;
  logic [XLEN-1:0] res_data_q;
  logic [XLEN-1:0] core_result;
  logic            in_fire, res_take, s1_adv;

  assign res_take = !res_valid_q || res_o.ready;
  assign s1_adv   = s1_valid_q && res_take;
  assign in_i.ready = !s1_valid_q || res_take;
  assign in_fire  = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !res_take);
  assign res_valid_d = s1_adv || (res_valid_q && !res_o.ready);

  rv64alu_core u_core (
    .item_i   (s1_item_q),
    .result_o (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.opcode         <= in_i.opcode;
      s1_item_q.funct3         <= in_i.funct3;
      s1_item_q.imm            <= in_i.imm;
      s1_item_q.first_operand  <= in_i.first_operand;
      s1_item_q.second_operand <= in_i.second_operand;
      s1_item_q.pc             <= in_i.pc;
    end
    if (s1_adv) begin
      res_data_q <= core_result;
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.result = res_data_q;

`ifndef SYNTHESIS
  // An accepted beat always lands in the input register.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted beat lost at input register");

  // A beat leaving the input register always fills the result register.
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> res_valid_q)
    else $error("beat lost between input and result registers");

  // The captured result is the datapath value of the advancing beat.
  a_res_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (res_data_q == $past(core_result)))
    else $error("result register does not hold the computed value");

  // Whenever the result side can drain, a new beat can be taken.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> in_i.ready)
    else $error("input stalled while the result side is free");
`endif

endmodule

[rtl/rv64alu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64alu_core
// Combinational datapath: a shared adder, a link adder, a 64-bit and a
// 32-bit shifter, compares and logic ops, selected by opcode and funct3.
// ----------------------------------------------------------------------------
module rv64alu_core
  import rv64alu_pkg::*;
(
  input  alu_item_t        item_i,
  output logic [XLEN-1:0]  result_o
);

  logic [XLEN-1:0]    a, b, imm64, add_b, sum, sll64, sr64, alu_b;
  logic [WLEN-1:0]    aw, sum32, sll32, sr32;
  logic [F7_W-1:0]    f7;
  logic               alt_imm, alt_op, is_op, do_sub, arith;
  logic [SHAMT_W-1:0] sh64;
  logic [SHW_W-1:0]   sh32;
  logic               lt_s, lt_u;

  assign a       = item_i.first_operand;
  assign b       = item_i.second_operand;
  assign imm64   = {{(XLEN-IMM_W){item_i.imm[IMM_W-1]}}, item_i.imm};
  assign aw      = a[WLEN-1:0];
  assign f7      = item_i.imm[IMM_W-1:IMM_W-F7_W];
  assign alt_imm = item_i.imm[IMM_ALT_BIT];
  assign alt_op  = (f7 == F7_ALT);
  assign is_op   = (item_i.opcode == OPC_OP);

  // The register operand only stands in for the immediate in OP forms.
  assign alu_b  = is_op ? b : imm64;
  assign do_sub = is_op && alt_op && (item_i.funct3 == F3_ADD);
  assign add_b  = do_sub ? ~alu_b : alu_b;
  assign sum    = a + add_b + {{(XLEN-1){1'b0}}, do_sub};
  assign sum32  = sum[WLEN-1:0];

  assign sh64  = is_op ? b[SHAMT_W-1:0] : item_i.imm[SHAMT_W-1:0];
  assign sh32  = item_i.imm[SHW_W-1:0];
  assign arith = is_op ? alt_op : alt_imm;

  // The arithmetic shifts sit inside their own self-determined context so
  // that the unsigned arm of the select cannot turn them into logical ones.
  assign sll64 = a << sh64;
  assign sr64  = arith ? $unsigned($signed(a) >>> sh64) : (a >> sh64);
  assign sll32 = aw << sh32;
  assign sr32  = alt_imm ? $unsigned($signed(aw) >>> sh32) : (aw >> sh32);

  // Branches compare against rs2, SLTI/SLTIU against the immediate.
  assign lt_s = ($signed(a) < $signed(alu_b)) || 1'b0;
  assign lt_u = (a < imm64);

  always_comb begin
    result_o = '0;
    unique case (item_i.opcode)
      OPC_OPIMM: begin
        unique case (item_i.funct3)
          F3_ADD:  result_o = sum;
          F3_SLL:  result_o = sll64;
          F3_SLT:  result_o = {{(XLEN-1){1'b0}}, lt_s};
          F3_SLTU: result_o = {{(XLEN-1){1'b0}}, lt_u};
          F3_XOR:  result_o = a ^ imm64;
          F3_SR:   result_o = sr64;
          F3_OR:   result_o = a | imm64;
          F3_AND:  result_o = a & imm64;
          default: result_o = '0;
        endcase
      end
      OPC_LOAD, OPC_STORE: result_o = sum;
      OPC_JAL, OPC_JALR:   result_o = item_i.pc + LINK_OFFSET;
      OPC_BRANCH: begin
        unique case (item_i.funct3)
          F3_BEQ:  result_o = {{(XLEN-1){1'b0}}, (a == b)};
          F3_BNE:  result_o = {{(XLEN-1){1'b0}}, (a != b)};
          F3_BLT:  result_o = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
          F3_BGE:  result_o = {{(XLEN-1){1'b0}}, !($signed(a) < $signed(b))};
          default: result_o = '0;
        endcase
      end
      OPC_OPIMM32: begin
        unique case (item_i.funct3)
          F3_ADD:  result_o = {{(XLEN-WLEN){sum32[WLEN-1]}}, sum32};
          F3_SLL:  result_o = {{(XLEN-WLEN){sll32[WLEN-1]}}, sll32};
          F3_SR:   result_o = {{(XLEN-WLEN){sr32[WLEN-1]}}, sr32};
          default: result_o = '0;
        endcase
      end
      OPC_OP: begin
        unique case (item_i.funct3)
          F3_ADD:  result_o = sum;
          F3_SLL:  result_o = sll64;
          F3_XOR:  result_o = a ^ b;
          F3_SR:   result_o = sr64;
          F3_OR:   result_o = a | b;
          F3_AND:  result_o = a & b;
          default: result_o = '0;
        endcase
      end
      default: result_o = '0;
    endcase
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RV64I execute-stage ALU. Directed instructions
// cover every operation, the field extremes and the corner cases. Random
// instructions then run under several sender and receiver idling patterns.
// Every result beat is checked against an in-bench model of the datapath.
// ----------------------------------------------------------------------------
module tb;
  import rv64alu_pkg::*;

  localparam logic [XLEN-1:0]  MAX_S64         = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [XLEN-1:0]  MIN_S64         = 64'h8000_0000_0000_0000;
  localparam logic [XLEN-1:0]  ALL_ONES        = '1;
  localparam logic [IMM_W-1:0] IMM_ARITH       = IMM_W'(1) << IMM_ALT_BIT;
  localparam logic [OPC_W-1:0] OPC_UNUSED      = 7'h7F;
  localparam int unsigned      ITEMS_PER_PHASE = 470;
  localparam int unsigned      SETTLE_CYCLES   = 8;
  localparam int unsigned      WATCHDOG_CYCLES = 2000;

  logic clk_i;
  logic rst_ni;

  rv64alu_in_if  in_ch ();
  rv64alu_out_if res_ch ();

  rv64i_execute_alu u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch)
  );

  logic [XLEN-1:0] expected_results[$];
  int unsigned     error_count;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     quiet_cycles;

  opcode_e known_opcodes[8] = '{OPC_LOAD, OPC_OPIMM, OPC_OPIMM32, OPC_STORE,
                                OPC_OP, OPC_BRANCH, OPC_JALR, OPC_JAL};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [XLEN-1:0] as_flag(input logic cond);
    return {{(XLEN-1){1'b0}}, cond};
  endfunction

  function automatic logic [XLEN-1:0] alu_result_of(input alu_item_t it);
    logic [XLEN-1:0]    a;
    logic [XLEN-1:0]    b;
    logic [XLEN-1:0]    imm_x;
    logic [XLEN-1:0]    word_x;
    logic [WLEN-1:0]    aw;
    logic [WLEN-1:0]    w;
    logic [F7_W-1:0]    f7;
    logic [SHAMT_W-1:0] sh_imm;
    logic [SHAMT_W-1:0] sh_reg;
    logic [SHW_W-1:0]   sh_word;
    logic               arith;
    logic [XLEN-1:0]    res;
    a       = it.first_operand;
    b       = it.second_operand;
    imm_x   = {{(XLEN-IMM_W){it.imm[IMM_W-1]}}, it.imm};
    arith   = it.imm[IMM_ALT_BIT];
    f7      = it.imm[IMM_W-1 -: F7_W];
    sh_imm  = it.imm[SHAMT_W-1:0];
    sh_word = it.imm[SHW_W-1:0];
    sh_reg  = b[SHAMT_W-1:0];
    aw      = a[WLEN-1:0];
    res     = '0;
    case (it.opcode)
      OPC_OPIMM: begin
        case (it.funct3)
          F3_ADD:  res = a + imm_x;
          F3_SLL:  res = a << sh_imm;
          F3_SLT:  res = as_flag($signed(a) < $signed(imm_x));
          F3_SLTU: res = as_flag(a < imm_x);
          F3_XOR:  res = a ^ imm_x;
          F3_SR: begin
            if (arith) res = $signed(a) >>> sh_imm;
            else res = a >> sh_imm;
          end
          F3_OR:   res = a | imm_x;
          default: res = a & imm_x;
        endcase
      end
      OPC_LOAD, OPC_STORE: res = a + imm_x;
      OPC_JAL, OPC_JALR:   res = it.pc + LINK_OFFSET;
      OPC_BRANCH: begin
        case (it.funct3)
          F3_BEQ:  res = as_flag(a == b);
          F3_BNE:  res = as_flag(a != b);
          F3_BLT:  res = as_flag($signed(a) < $signed(b));
          F3_BGE:  res = as_flag($signed(a) >= $signed(b));
          default: res = '0;
        endcase
      end
      OPC_OPIMM32: begin
        case (it.funct3)
          F3_ADD: begin
            w   = aw + imm_x[WLEN-1:0];
            res = {{(XLEN-WLEN){w[WLEN-1]}}, w};
          end
          F3_SLL: begin
            w   = aw << sh_word;
            res = {{(XLEN-WLEN){w[WLEN-1]}}, w};
          end
          F3_SR: begin
            // The arithmetic form shifts the sign-extended word, so the
            // vacated upper bits follow bit 31 of the source.
            if (arith) begin
              word_x = {{(XLEN-WLEN){aw[WLEN-1]}}, aw};
              res    = $signed(word_x) >>> sh_word;
            end else begin
              w   = aw >> sh_word;
              res = {{(XLEN-WLEN){w[WLEN-1]}}, w};
            end
          end
          default: res = '0;
        endcase
      end
      OPC_OP: begin
        case (it.funct3)
          F3_ADD: begin
            if (f7 == F7_ALT) res = a - b;
            else res = a + b;
          end
          F3_SLL: res = a << sh_reg;
          F3_XOR: res = a ^ b;
          F3_SR: begin
            if (f7 == F7_ALT) res = $signed(a) >>> sh_reg;
            else res = a >> sh_reg;
          end
          F3_OR:   res = a | b;
          F3_AND:  res = a & b;
          default: res = '0;
        endcase
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                 input logic [XLEN-1:0] want);
    $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Expectations are queued on the instruction beat and retired on the
  // result beat; both are sampled at the edge on which they are accepted.
  always @(posedge clk_i) begin : check_results
    alu_item_t       insn;
    logic [XLEN-1:0] want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", res_ch.result, 'x);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.result !== want) report_mismatch("result", res_ch.result, want);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        insn.opcode         = in_ch.opcode;
        insn.funct3         = in_ch.funct3;
        insn.imm            = in_ch.imm;
        insn.first_operand  = in_ch.first_operand;
        insn.second_operand = in_ch.second_operand;
        insn.pc             = in_ch.pc;
        expected_results.push_back(alu_result_of(insn));
      end
    end
  end

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_insn(input logic [OPC_W-1:0] opcode, input logic [F3_W-1:0] funct3,
                           input logic [IMM_W-1:0] imm, input logic [XLEN-1:0] a,
                           input logic [XLEN-1:0] b, input logic [XLEN-1:0] pc);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= opcode;
    in_ch.funct3         <= funct3;
    in_ch.imm            <= imm;
    in_ch.first_operand  <= a;
    in_ch.second_operand <= b;
    in_ch.pc             <= pc;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Holds the sender off until every pending result has been checked.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] v;
    case ($urandom_range(0, 5))
      0: v = XLEN'($urandom_range(0, 64)) - XLEN'(32);
      1: begin
        case ($urandom_range(0, 3))
          0: v = MAX_S64;
          1: v = MIN_S64;
          2: v = '0;
          default: v = ALL_ONES;
        endcase
      end
      2: v = {$urandom, ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic test_opimm_forms();
    send_insn(OPC_OPIMM, F3_ADD,  12'h001, MAX_S64, '0, '0);
    send_insn(OPC_OPIMM, F3_SLT,  12'h7FF, MIN_S64, '0, '0);
    // The negative immediate is compared as a huge unsigned value.
    send_insn(OPC_OPIMM, F3_SLTU, 12'h800, 64'd5, '0, '0);
    send_insn(OPC_OPIMM, F3_XOR,  12'hFFF, 64'h0123_4567_89AB_CDEF, '0, '0);
    send_insn(OPC_OPIMM, F3_OR,   12'h800, '0, '0, '0);
    send_insn(OPC_OPIMM, F3_AND,  12'h7FF, ALL_ONES, '0, '0);
    send_insn(OPC_OPIMM, F3_SLL,  12'hFC1, MAX_S64, '0, '0);
    send_insn(OPC_OPIMM, F3_SR,   12'h03F, MIN_S64, '0, '0);
    send_insn(OPC_OPIMM, F3_SR,   IMM_ARITH | 12'h03F, MIN_S64, '0, '0);
  endtask

  task automatic test_op_forms();
    send_insn(OPC_OP, F3_ADD, {F7_ALT, 5'h00}, MIN_S64, 64'd1, '0);
    // Any funct7 other than the exact alternate code selects the plain add.
    send_insn(OPC_OP, F3_ADD, {F7_ALT ^ 7'h01, 5'h1F}, MAX_S64, 64'd1, '0);
    send_insn(OPC_OP, F3_SLL, '0, 64'd1, 64'd67, '0);
    send_insn(OPC_OP, F3_XOR, '0, ALL_ONES, MAX_S64, '0);
    send_insn(OPC_OP, F3_SR,  '0, MIN_S64, 64'd63, '0);
    send_insn(OPC_OP, F3_SR,  {F7_ALT, 5'h00}, MIN_S64, ALL_ONES, '0);
    send_insn(OPC_OP, F3_OR,  '0, MIN_S64, 64'd1, '0);
    send_insn(OPC_OP, F3_AND, '0, ALL_ONES, MIN_S64, '0);
  endtask

  task automatic test_memory_and_link();
    send_insn(OPC_LOAD,  F3_ADD, 12'h800, '0, '0, '0);
    send_insn(OPC_STORE, F3_SLT, 12'h7FF, MAX_S64, '0, '0);
    send_insn(OPC_JAL,   F3_ADD, 12'hFFF, '0, '0, ALL_ONES);
    send_insn(OPC_JALR,  F3_AND, '0, ALL_ONES, ALL_ONES, 64'h0000_0000_8000_0000);
  endtask

  task automatic test_branches();
    send_insn(OPC_BRANCH, F3_BEQ, '0, MIN_S64, MIN_S64, '0);
    send_insn(OPC_BRANCH, F3_BNE, '0, ALL_ONES, ALL_ONES, '0);
    send_insn(OPC_BRANCH, F3_BLT, '0, MIN_S64, MAX_S64, '0);
    send_insn(OPC_BRANCH, F3_BGE, '0, MAX_S64, MAX_S64, '0);
    send_insn(OPC_BRANCH, F3_SLT, '0, MIN_S64, MAX_S64, '0);
  endtask

  task automatic test_word_forms();
    send_insn(OPC_OPIMM32, F3_ADD, 12'h001, 64'hFFFF_FFFF_7FFF_FFFF, '0, '0);
    send_insn(OPC_OPIMM32, F3_SLL, 12'hFFF, 64'd1, '0, '0);
    // Bit 5 of the immediate lies outside the word shift amount.
    send_insn(OPC_OPIMM32, F3_SR,  12'h020, 64'h0000_0000_8000_0000, '0, '0);
    send_insn(OPC_OPIMM32, F3_SR,  IMM_ARITH | 12'h004, 64'h0000_0000_8000_0000, '0, '0);
  endtask

  task automatic test_unhandled();
    send_insn(OPC_UNUSED,  F3_ADD,  12'h7FF, ALL_ONES, ALL_ONES, ALL_ONES);
    send_insn(OPC_OP,      F3_SLTU, '0, '0, ALL_ONES, '0);
    send_insn(OPC_OPIMM32, F3_AND,  12'hFFF, ALL_ONES, '0, '0);
  endtask

  task automatic send_random_insn();
    logic [OPC_W-1:0] opcode;
    logic [F3_W-1:0]  funct3;
    logic [IMM_W-1:0] imm;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
    logic [XLEN-1:0]  pc;
    if ($urandom_range(0, 99) < 88) opcode = known_opcodes[$urandom_range(0, 7)];
    else opcode = OPC_W'($urandom);
    funct3 = F3_W'($urandom);
    imm    = IMM_W'($urandom);
    if (opcode == OPC_OP && $urandom_range(0, 9) < 6) begin
      imm[IMM_W-1 -: F7_W] = ($urandom_range(0, 1) != 0) ? F7_ALT : '0;
    end
    a = pick_operand();
    if (opcode == OPC_BRANCH && $urandom_range(0, 3) == 0) b = a;
    else b = pick_operand();
    if ($urandom_range(0, 7) == 0) pc = ALL_ONES - XLEN'($urandom_range(0, 15));
    else pc = {$urandom, $urandom};
    send_insn(opcode, funct3, imm, a, b, pc);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (ITEMS_PER_PHASE) send_random_insn();
    drain_results();
  endtask

  task automatic test_random();
    run_random_phase(0, 0);
    run_random_phase(57, 0);
    run_random_phase(0, 57);
    run_random_phase(16, 16);
  endtask

  initial begin
    error_count          = 0;
    quiet_cycles         = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = '0;
    in_ch.funct3         = '0;
    in_ch.imm            = '0;
    in_ch.first_operand  = '0;
    in_ch.second_operand = '0;
    in_ch.pc             = '0;
    res_ch.ready         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_opimm_forms();
    test_op_forms();
    test_memory_and_link();
    test_branches();
    test_word_forms();
    test_unhandled();
    drain_results();
    test_random();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", '0, expected_results[0]);
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[files.f]
rtl/rv64alu_pkg.sv
rtl/rv64alu_in_if.sv
rtl/rv64alu_out_if.sv
rtl/rv64alu_core.sv
rtl/rv64i_execute_alu.sv
tb/tb.sv
